@@ rtl/kappa_scheme_face_flux_macros.svh @@
`ifndef KAPPA_SCHEME_FACE_FLUX_MACROS_SVH
`define KAPPA_SCHEME_FACE_FLUX_MACROS_SVH
// Assertion helpers; each expects clk and arst_n in scope.

// Same-cycle implication.
`define KSFF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("face flux check failed");

// Next-cycle implication.
`define KSFF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("face flux check failed");

`endif

@@ rtl/ksff_pkg.sv @@
`default_nettype none
package ksff_pkg;

	localparam int KAPPA_W = 18;
	localparam logic signed [KAPPA_W-1:0] KAPPA_HALF = 18'sd32768;
	localparam int KAPPA_SHIFT = 18;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_RND, S_LMUL, S_LSUM, S_QSUM, S_QPRE,
		S_QDIV, S_QCLS, S_QSQ, S_QSQF, S_QMUL, S_QFIN, S_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic mul;
		logic acc;
		logic rnd;
		logic lmul;
		logic lsum;
		logic qsum;
		logic qpre;
		logic div_step;
		logic qcls;
		logic sq_step;
		logic sq_fin;
		logic qmul;
		logic qfin;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
		logic bnd;
		logic quick;
		logic skip;
		logic need_sqrt;
		logic iter_done;
		logic out_busy;
	} stat_t;

	// clamp to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ksff_ctrl.sv @@
`default_nettype none
module ksff_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire ksff_pkg::stat_t st,
	output ksff_pkg::cmd_t       cmd
);
	import ksff_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_MUL;
			S_MUL:  state_d = S_ACC;
			S_ACC:  state_d = st.last ? S_RND : S_IDLE;
			S_RND: begin
				if (st.bnd) state_d = S_FIN;
				else if (st.quick) state_d = S_QSUM;
				else state_d = S_LMUL;
			end
			S_LMUL: state_d = S_LSUM;
			S_LSUM: state_d = S_FIN;
			S_QSUM: state_d = S_QPRE;
			S_QPRE: state_d = st.skip ? S_QMUL : S_QDIV;
			S_QDIV: if (st.iter_done) state_d = S_QCLS;
			S_QCLS: state_d = st.need_sqrt ? S_QSQ : S_QMUL;
			S_QSQ:  if (st.iter_done) state_d = S_QSQF;
			S_QSQF: state_d = S_QMUL;
			S_QMUL: state_d = S_QFIN;
			S_QFIN: state_d = S_FIN;
			S_FIN:  if (!st.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			S_MUL:  cmd.mul = 1'b1;
			S_ACC:  cmd.acc = 1'b1;
			S_RND:  cmd.rnd = 1'b1;
			S_LMUL: cmd.lmul = 1'b1;
			S_LSUM: cmd.lsum = 1'b1;
			S_QSUM: cmd.qsum = 1'b1;
			S_QPRE: cmd.qpre = 1'b1;
			S_QDIV: cmd.div_step = 1'b1;
			S_QCLS: cmd.qcls = 1'b1;
			S_QSQ:  cmd.sq_step = 1'b1;
			S_QSQF: cmd.sq_fin = 1'b1;
			S_QMUL: cmd.qmul = 1'b1;
			S_QFIN: cmd.qfin = 1'b1;
			S_FIN:  cmd.out_load = !st.out_busy;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/ksff_dp.sv @@
`default_nettype none
module ksff_dp #(
	parameter int SPACE_DIMS = 3,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ksff_pkg::cmd_t       cmd,
	output ksff_pkg::stat_t           st,
	input  wire logic                 cfg_we,
	input  wire logic signed [17:0]   cfg_wdata,
	input  wire logic signed [31:0]   normal_velocity,
	input  wire logic                 at_boundary,
	input  wire logic signed [31:0]   value_first,
	input  wire logic signed [31:0]   value_second,
	input  wire logic signed [31:0]   offset_part,
	input  wire logic signed [31:0]   grad_own_part,
	input  wire logic signed [31:0]   grad_neighbour_part,
	input  wire logic                 last_part,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [31:0]        face_flux,
	output logic [30:0]               inflow_first,
	output logic [30:0]               inflow_second
);
	import ksff_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int CW   = $clog2(SPACE_DIMS + 1);
	localparam int IW   = $clog2(F + 3);
	localparam int NW   = 32 + F;
	localparam int QW   = F + 2;
	localparam int UW   = F + 3;
	localparam longint EPS_L = ((64'sd1 <<< F) + 50000) / 100000;
	localparam logic [32:0] EPS = 33'(EPS_L);
	localparam logic signed [UW-1:0] ONE_U = UW'(1) <<< F;
	localparam logic signed [UW-1:0] ONEHALF_U = UW'(3) <<< (F - 1);
	localparam logic signed [UW-1:0] QUART_U = UW'(1) <<< (F - 2);
	localparam logic [F-1:0] HALF_F = F'(1) << (F - 1);
	localparam logic [F-1:0] EIGHTH_F = F'(1) << (F - 3);
	localparam logic signed [64:0] LIM = 65'sd1 <<< 62;

	// config and input word
	logic signed [17:0] kappa_q;
	logic signed [31:0] v_q, a_q, b_q, o_q, go_q, gn_q;
	logic bnd_q, last_q;
	// projections
	logic signed [63:0] p0_q, p1_q, proj0_q, proj1_q;
	logic [CW-1:0] cnt_q;
	// result operands
	logic signed [31:0] d0_q, d1_q, up_q, flux_q;
	logic [30:0] inf1_q, inf2_q;
	logic signed [50:0] lm0_q, lm1_q;
	logic signed [32:0] t_q;
	// divider and root
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [QW-1:0] nlo_q, quo_q;
	logic [IW-1:0] it_q;
	logic [2*F-1:0] sqm_q;
	logic [F+2:0] srem_q;
	logic [F-1:0] root_q, cf_q;
	logic signed [32+F:0] qp0_q, qp1_q;
	logic out_valid_q;
	logic signed [31:0] out_flux_q;
	logic [30:0] out_inf1_q, out_inf2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kappa_q <= KAPPA_HALF;
		else if (cfg_we) kappa_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q <= normal_velocity;
			bnd_q <= at_boundary;
			a_q <= value_first;
			b_q <= value_second;
			o_q <= offset_part;
			go_q <= grad_own_part;
			gn_q <= grad_neighbour_part;
			last_q <= last_part;
		end
		if (cmd.mul) begin
			p0_q <= go_q * o_q;
			p1_q <= gn_q * o_q;
		end
	end

	// saturating accumulate, negated for negative velocity
	logic signed [64:0] s0, s1, c0, c1;
	always_comb begin
		s0 = 65'(proj0_q) + (v_q[31] ? -65'(p0_q) : 65'(p0_q));
		s1 = 65'(proj1_q) + (v_q[31] ? -65'(p1_q) : 65'(p1_q));
		c0 = (s0 > LIM) ? LIM : ((s0 < -LIM) ? -LIM : s0);
		c1 = (s1 > LIM) ? LIM : ((s1 < -LIM) ? -LIM : s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj0_q <= '0;
			proj1_q <= '0;
			cnt_q <= '0;
		end else if (cmd.rnd) begin
			proj0_q <= '0;
			proj1_q <= '0;
			cnt_q <= '0;
		end else if (cmd.acc && cnt_q < CW'(SPACE_DIMS)) begin
			proj0_q <= c0[63:0];
			proj1_q <= c1[63:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// rounding of projections, upwind value, inflows
	logic signed [64:0] r0, r1;
	always_comb begin
		r0 = (65'(proj0_q) + (65'sd1 <<< (F - 1))) >>> F;
		r1 = (65'(proj1_q) + (65'sd1 <<< (F - 1))) >>> F;
	end

	// linear blend
	logic signed [18:0] kp, km;
	logic signed [51:0] lsum;
	logic signed [33:0] lcorr;
	logic signed [34:0] lres;
	always_comb begin
		kp = 19'sd65536 + 19'(kappa_q);
		km = 19'sd65536 - 19'(kappa_q);
		lsum = 52'(lm0_q) + 52'(lm1_q) + (52'sd1 <<< (KAPPA_SHIFT - 1));
		lcorr = 34'(lsum >>> KAPPA_SHIFT);
		lres = 35'(up_q) + 35'(lcorr);
	end

	// quick blend: magnitudes for the divider
	logic [31:0] d1_abs;
	logic [32:0] t_abs;
	logic [NW-1:0] num;
	logic [34+F:0] den_big;
	logic [33:0] rem_sh;
	logic [33:0] rem_sub;
	logic div_ge;
	always_comb begin
		d1_abs = d1_q[31] ? (~d1_q + 1'b1) : d1_q;
		t_abs = t_q[32] ? 33'(-t_q) : 33'(t_q);
		num = {d1_abs, {F{1'b0}}};
		den_big = {t_abs, {(F + 2){1'b0}}};
		rem_sh = {rem_q[32:0], nlo_q[QW-1]};
		rem_sub = rem_sh - 34'(den_q);
		div_ge = rem_sh >= 34'(den_q);
	end

	// ratio classification
	logic signed [UW-1:0] u;
	logic [UW-1:0] nu, ud;
	logic [UW+1:0] nu3;
	logic [F-1:0] cf_cls;
	logic cls_sqrt;
	always_comb begin
		u = (d1_q[31] ^ t_q[32]) ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		nu = UW'(-u);
		nu3 = (UW + 2)'(nu) * (UW + 2)'(3);
		ud = (u >= ONE_U) ? UW'(u - ONE_U) : UW'(ONE_U - u);
		cls_sqrt = 1'b0;
		if (u <= -ONE_U || u >= ONEHALF_U) cf_cls = EIGHTH_F;
		else if (u <= 0) cf_cls = HALF_F - F'(nu3 >> 3);
		else if (u <= QUART_U) begin
			cf_cls = EIGHTH_F;
			cls_sqrt = 1'b1;
		end else cf_cls = F'(ud >> 2);
	end

	// root digit step
	logic [F+2:0] srem_sh, strial;
	logic [F+2:0] root5;
	always_comb begin
		srem_sh = {srem_q[F:0], sqm_q[2*F-1 -: 2]};
		strial = {1'b0, root_q, 2'b01};
		root5 = (F + 3)'(root_q) * (F + 3)'(5);
	end

	// quick final sum
	logic signed [34+F:0] qsum;
	logic signed [34:0] qres;
	always_comb begin
		qsum = (35 + F)'(qp0_q) + (35 + F)'(qp1_q) + ((35 + F)'(1) <<< (F - 1));
		qres = 35'(qsum >>> F);
		qres = qres + 35'(up_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			d0_q <= sat32(r0[63:0]);
			d1_q <= sat32(r1[63:0]);
			up_q <= v_q[31] ? b_q : a_q;
			flux_q <= v_q[31] ? b_q : a_q;
			inf1_q <= v_q[31] ? ((v_q == 32'sh80000000) ? 31'h7fffffff : 31'(-v_q)) : '0;
			inf2_q <= v_q[31] ? '0 : v_q[30:0];
		end
		if (cmd.lmul) begin
			lm0_q <= 51'(kp) * 51'(d0_q);
			lm1_q <= 51'(km) * 51'(d1_q);
		end
		if (cmd.lsum) flux_q <= sat32(64'(lres));
		if (cmd.qsum) t_q <= 33'(d0_q) + 33'(d1_q);
		if (cmd.qpre) begin
			cf_q <= EIGHTH_F;
			den_q <= t_abs;
			rem_q <= 34'(num >> QW);
			nlo_q <= num[QW-1:0];
			quo_q <= '0;
			it_q <= IW'(QW - 1);
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? rem_sub : rem_sh;
			quo_q <= {quo_q[QW-2:0], div_ge};
			nlo_q <= nlo_q << 1;
			it_q <= it_q - 1'b1;
		end
		if (cmd.qcls) begin
			cf_q <= cf_cls;
			sqm_q <= {u[F-1:0], {F{1'b0}}};
			srem_q <= '0;
			root_q <= '0;
			it_q <= IW'(F - 1);
		end
		if (cmd.sq_step) begin
			if (srem_sh >= strial) begin
				srem_q <= srem_sh - strial;
				root_q <= {root_q[F-2:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				root_q <= {root_q[F-2:0], 1'b0};
			end
			sqm_q <= sqm_q << 2;
			it_q <= it_q - 1'b1;
		end
		if (cmd.sq_fin) cf_q <= HALF_F - F'(root5 >> 3);
		if (cmd.qmul) begin
			qp0_q <= d0_q * $signed({1'b0, HALF_F - cf_q});
			qp1_q <= d1_q * $signed({1'b0, cf_q});
		end
		if (cmd.qfin) flux_q <= sat32(64'(qres));
		if (cmd.out_load) begin
			out_flux_q <= flux_q;
			out_inf1_q <= inf1_q;
			out_inf2_q <= inf2_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	// skip and root decisions are taken in the cycle they are formed
	always_comb begin
		st.last = last_q;
		st.bnd = bnd_q;
		st.quick = (kappa_q == KAPPA_HALF);
		st.skip = (t_abs <= EPS) || ((35 + F)'(num) >= den_big);
		st.need_sqrt = cls_sqrt;
		st.iter_done = (it_q == '0);
		st.out_busy = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign face_flux = out_flux_q;
	assign inflow_first = out_inf1_q;
	assign inflow_second = out_inf2_q;
endmodule
`default_nettype wire

@@ rtl/kappa_scheme_face_flux.sv @@
// A word without last_part is loaded, multiplied and accumulated.
// A last word is then rounded; a boundary word finishes at once, the linear kappa
// blend adds a multiply and a sum, and the QUICK blend a bit-serial divider and square root unit.
// One word is in flight at a time; the output register frees the input side.
// Reset (arst_n low) clears both projections, the count and the output valid,
// and sets kappa to 0.5.
`default_nettype none
module kappa_scheme_face_flux #(
	parameter int SPACE_DIMS = 3,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic signed [17:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] normal_velocity,
	input  wire logic               at_boundary,
	input  wire logic signed [31:0] value_first,
	input  wire logic signed [31:0] value_second,
	input  wire logic signed [31:0] offset_part,
	input  wire logic signed [31:0] grad_own_part,
	input  wire logic signed [31:0] grad_neighbour_part,
	input  wire logic               last_part,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      face_flux,
	output logic [30:0]             inflow_first,
	output logic [30:0]             inflow_second
);
	import ksff_pkg::*;

	cmd_t  cmd;
	stat_t st;

	ksff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	ksff_dp #(
		.SPACE_DIMS (SPACE_DIMS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.st                  (st),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.normal_velocity     (normal_velocity),
		.at_boundary         (at_boundary),
		.value_first         (value_first),
		.value_second        (value_second),
		.offset_part         (offset_part),
		.grad_own_part       (grad_own_part),
		.grad_neighbour_part (grad_neighbour_part),
		.last_part           (last_part),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.face_flux           (face_flux),
		.inflow_first        (inflow_first),
		.inflow_second       (inflow_second)
	);
endmodule
`default_nettype wire

@@ rtl/ksff_check.sv @@
`default_nettype none
`include "kappa_scheme_face_flux_macros.svh"
module ksff_check (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] face_flux,
	input wire logic [30:0]        inflow_first,
	input wire logic [30:0]        inflow_second
);
	// a waiting word stays
	`KSFF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// a waiting word keeps its value
	`KSFF_ASSERT_NEXT(a_flux_hold, out_valid && out_stall, $stable(face_flux))
	// only one face takes inflow
	`KSFF_ASSERT_NOW(a_one_inflow, out_valid && inflow_first != '0, inflow_second == '0)
	// the block is busy right after taking a word
	`KSFF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
endmodule

bind kappa_scheme_face_flux ksff_check u_ksff_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.face_flux     (face_flux),
	.inflow_first  (inflow_first),
	.inflow_second (inflow_second)
);
`default_nettype wire
